// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the 2-opt move engine.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/tome_pkg.sv -----
// Package for the 2-opt move engine: action and status codes, payload structs.
// No dependencies; used by tome_move_check and two_opt_move_engine_top.
package tome_pkg;

  localparam int NODE_BITS  = 6;
  localparam int POS_BITS   = 7;
  localparam int VALUE_BITS = 32;
  localparam int LEN_BITS   = 7;

  localparam logic [LEN_BITS-1:0] TOUR_LEN_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_WRITE_DIST = 2'd0,
    ACT_WRITE_TOUR = 2'd1,
    ACT_MOVE       = 2'd2,
    ACT_READ_TOUR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_APPLIED = 2'd1,
    ST_REJECT  = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    action_t               action;
    logic [NODE_BITS-1:0]  row_node;
    logic [NODE_BITS-1:0]  col_node;
    logic [VALUE_BITS-1:0] dist_value;
    logic [POS_BITS-1:0]   pos_a;
    logic [POS_BITS-1:0]   pos_b;
    logic [NODE_BITS-1:0]  node_in;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [NODE_BITS-1:0] node_out;
  } result_t;

  // Move check: positions legal, and j sits at the tour end (D wraps).
  typedef struct packed {
    logic ok;
    logic wrap;
  } move_chk_t;

endpackage

// ----- rtl/tome_move_check.sv -----
// Move position check for the 2-opt move engine.
// Saturates the tour length and validates positions i and j. Depends on tome_pkg.
module tome_move_check #(
  parameter int MAX_NODES = 64
) (
  input  logic [tome_pkg::LEN_BITS-1:0] tour_length,
  input  logic [tome_pkg::POS_BITS-1:0] pos_a,
  input  logic [tome_pkg::POS_BITS-1:0] pos_b,
  output tome_pkg::move_chk_t           chk
);

  logic [tome_pkg::LEN_BITS-1:0] n;
  logic [tome_pkg::POS_BITS:0]   a8;
  logic [tome_pkg::POS_BITS:0]   b8;
  logic [tome_pkg::POS_BITS:0]   n8;

  always_comb begin
    n = (32'(tour_length) > 32'(MAX_NODES)) ? tome_pkg::LEN_BITS'(MAX_NODES) : tour_length;
    a8 = {1'b0, pos_a};
    b8 = {1'b0, pos_b};
    n8 = (tome_pkg::POS_BITS + 1)'(n);
    chk.ok = (n8 >= 8'd4) && (a8 >= 8'd1) && (a8 + 8'd2 <= n8) &&
             (b8 >= a8 + 8'd2) && (b8 <= n8) && !((a8 == 8'd1) && (b8 == n8));
    chk.wrap = (b8 == n8);
  end

endmodule

// ----- rtl/two_opt_move_engine_top.sv -----
// An applied move swaps p = floor((j - i) / 2) pairs of tour entries.
// One item at a time: busy stays high until the result strobe, next transfer from that cycle.
// The segment swap goes pair by pair through the single write port of the tour RAM.
// Sync reset clears control and sets tour_length to 64; both RAMs are undefined until written.
// Results are strobed by done for one cycle and cannot be stalled.
module two_opt_move_engine_top #(
  parameter int MAX_NODES = 64,
  parameter int DIST_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tome_pkg::item_t               item,
  output logic                          done,
  output tome_pkg::result_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tome_pkg::LEN_BITS-1:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int DADDR_W = 2 * IDX_W;
  localparam int DDEPTH  = 2 ** DADDR_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_OUT  = 7'b0000100,
    S_TOUR = 7'b0001000,
    S_DIST = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_SWAP = 7'b1000000
  } state_t;

  state_t                               state;
  tome_pkg::item_t                      req;
  logic [tome_pkg::LEN_BITS-1:0]        tour_length;
  logic [2:0]                           k;
  logic [tome_pkg::NODE_BITS-1:0]       na, nb, nc, nd;
  logic [DIST_BITS-1:0]                 dreg [4];
  logic                                 dok_q;
  logic [IDX_W-1:0]                     lo, hi, hi_prev;
  logic                                 ph;
  logic                                 wr_pend;
  logic [tome_pkg::NODE_BITS-1:0]       hold;
  tome_pkg::move_chk_t                  chk;

  logic [tome_pkg::NODE_BITS-1:0]       tour_mem [MAX_NODES];
  logic [tome_pkg::NODE_BITS-1:0]       rd0, rd1;
  logic [IDX_W-1:0]                     t_raddr0, t_raddr1, t_waddr;
  logic                                 t_we;
  logic [tome_pkg::NODE_BITS-1:0]       t_wdata;

  logic [DIST_BITS-1:0]                 dist_mem [DDEPTH];
  logic [DIST_BITS-1:0]                 drd;
  logic [DADDR_W-1:0]                   d_raddr, d_waddr;
  logic                                 d_we;
  logic                                 dok;
  logic [tome_pkg::NODE_BITS-1:0]       dx, dy;

  logic [IDX_W-1:0]                     pa_idx, pb_idx, pa_nxt, d_idx;
  logic                                 pos_ok;
  logic [DIST_BITS:0]                   cost_old, cost_new;

  tome_move_check #(
    .MAX_NODES(MAX_NODES)
  ) u_check (
    .tour_length(tour_length),
    .pos_a      (req.pos_a),
    .pos_b      (req.pos_b),
    .chk        (chk)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    pa_idx   = IDX_W'(req.pos_a - 7'd1);
    pb_idx   = IDX_W'(req.pos_b - 7'd1);
    pa_nxt   = IDX_W'(req.pos_a);
    d_idx    = chk.wrap ? '0 : IDX_W'(req.pos_b);
    pos_ok   = (req.pos_a != '0) && (32'(req.pos_a) <= 32'(MAX_NODES));
    cost_old = {1'b0, dreg[0]} + {1'b0, dreg[1]};
    cost_new = {1'b0, dreg[2]} + {1'b0, dreg[3]};
  end

  // tour RAM port control
  always_comb begin
    t_raddr0 = pa_idx;
    t_raddr1 = pa_nxt;
    t_we     = 1'b0;
    t_waddr  = pa_idx;
    t_wdata  = req.node_in;
    case (state)
      S_EXEC: begin
        t_we = (req.action == tome_pkg::ACT_WRITE_TOUR) && pos_ok;
      end
      S_TOUR: begin
        if (k != 3'd0) begin
          t_raddr0 = pb_idx;
          t_raddr1 = d_idx;
        end
      end
      S_SWAP: begin
        t_raddr0 = lo;
        t_raddr1 = hi;
        if (ph) begin
          t_we    = 1'b1;
          t_waddr = lo;
          t_wdata = rd1;
        end else begin
          t_we    = wr_pend;
          t_waddr = hi_prev;
          t_wdata = hold;
        end
      end
      default: begin
      end
    endcase
  end

  // distance RAM port control: edges (A,B) (C,D) (A,C) (B,D)
  always_comb begin
    case (k)
      3'd0: begin
        dx = na;
        dy = nb;
      end
      3'd1: begin
        dx = nc;
        dy = nd;
      end
      3'd2: begin
        dx = na;
        dy = nc;
      end
      default: begin
        dx = nb;
        dy = nd;
      end
    endcase
    dok     = (32'(dx) < 32'(MAX_NODES)) && (32'(dy) < 32'(MAX_NODES));
    d_raddr = {IDX_W'(dx), IDX_W'(dy)};
    d_waddr = {IDX_W'(req.row_node), IDX_W'(req.col_node)};
    d_we    = (state == S_EXEC) && (req.action == tome_pkg::ACT_WRITE_DIST) &&
              (32'(req.row_node) < 32'(MAX_NODES)) && (32'(req.col_node) < 32'(MAX_NODES));
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tour_mem[t_waddr] <= t_wdata;
    end
    rd0 <= tour_mem[t_raddr0];
    rd1 <= tour_mem[t_raddr1];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dist_mem[d_waddr] <= DIST_BITS'(req.dist_value);
    end
    drd <= dist_mem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      tour_length <= tome_pkg::TOUR_LEN_RESET;
      k           <= 3'd0;
      ph          <= 1'b0;
      wr_pend     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        tour_length <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req   <= item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          k <= 3'd0;
          case (req.action)
            tome_pkg::ACT_MOVE: begin
              if (chk.ok) begin
                state <= S_TOUR;
              end else begin
                done            <= 1'b1;
                result.status   <= tome_pkg::ST_INVALID;
                result.node_out <= '0;
                state           <= S_IDLE;
              end
            end
            tome_pkg::ACT_READ_TOUR: begin
              state <= S_OUT;
            end
            default: begin
              done            <= 1'b1;
              result.status   <= tome_pkg::ST_DONE;
              result.node_out <= '0;
              state           <= S_IDLE;
            end
          endcase
        end
        S_OUT: begin
          done            <= 1'b1;
          result.status   <= tome_pkg::ST_DONE;
          result.node_out <= pos_ok ? rd0 : '0;
          state           <= S_IDLE;
        end
        S_TOUR: begin
          if (k == 3'd1) begin
            na <= rd0;
            nb <= rd1;
          end else if (k == 3'd2) begin
            nc <= rd0;
            nd <= rd1;
          end
          if (k == 3'd2) begin
            k     <= 3'd0;
            state <= S_DIST;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_DIST: begin
          dok_q <= dok;
          if (k != 3'd0) begin
            dreg[2'(k - 3'd1)] <= dok_q ? drd : '0;
          end
          if (k == 3'd4) begin
            state <= S_CMP;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_CMP: begin
          if (cost_old > cost_new) begin
            lo      <= pa_nxt;
            hi      <= pb_idx;
            ph      <= 1'b0;
            wr_pend <= 1'b0;
            state   <= S_SWAP;
          end else begin
            done            <= 1'b1;
            result.status   <= tome_pkg::ST_REJECT;
            result.node_out <= '0;
            state           <= S_IDLE;
          end
        end
        S_SWAP: begin
          if (ph) begin
            hold    <= rd0;
            hi_prev <= hi;
            wr_pend <= 1'b1;
            lo      <= lo + IDX_W'(1);
            hi      <= hi - IDX_W'(1);
            ph      <= 1'b0;
          end else begin
            wr_pend <= 1'b0;
            if (lo < hi) begin
              ph <= 1'b1;
            end else begin
              done            <= 1'b1;
              result.status   <= tome_pkg::ST_APPLIED;
              result.node_out <= '0;
              state           <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_done_pulse, done, !done, "done strobe longer than one cycle")
  `ASSERT_IMPLY(a_done_idle, done, !busy, "result strobed while still busy")
  `ASSERT_NEXT(a_start_busy, start && !busy, busy, "transfer did not raise busy")
  `ASSERT_IMPLY(a_swap_order, (state == S_SWAP) && ph, lo < hi, "swap pair out of order")
  `ASSERT_IMPLY(a_plain_status, done && (req.action != tome_pkg::ACT_MOVE),
                result.status == tome_pkg::ST_DONE, "write or read gave a move status")

endmodule
